@@ design/rsp_pkg.sv @@
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared types, character codes and helpers for the RSP packet receiver.
// ----------------------------------------------------------------------------
package rsp_pkg;

  localparam int MaxLenDefault = 128;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_END   = 8'h23;
  localparam logic [7:0] CH_ESC   = 8'h7d;
  localparam logic [7:0] CH_ACK   = 8'h2b;
  localparam logic [7:0] CH_NAK   = 8'h2d;
  localparam logic [7:0] ESC_XOR  = 8'h20;

  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_ACK     = 3'd1,
    KIND_NAK     = 3'd2,
    KIND_RESTART = 3'd3,
    KIND_ABORT   = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  value;
    logic [7:0]  length;
  } result_t;

  // Hex digit of either case; bit 4 set when the byte is no digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] d;
    d = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = {1'b0, 4'(c - 8'h37)};
    end
    return d;
  endfunction

endpackage

@@ design/rsp_core.sv @@
// ----------------------------------------------------------------------------
// rsp_core
// Packet state, running checksum and byte count; one received byte per step.
// ----------------------------------------------------------------------------
module rsp_core #(
  parameter int MAX_LEN = rsp_pkg::MaxLenDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output logic             res_valid,
  output rsp_pkg::result_t res
);

  typedef enum logic [4:0] {
    PH_HUNT = 5'b00001,
    PH_BODY = 5'b00010,
    PH_ESC  = 5'b00100,
    PH_CKHI = 5'b01000,
    PH_CKLO = 5'b10000
  } phase_t;

  localparam logic [8:0] MaxLenW = 9'(MAX_LEN);

  phase_t     phase, phase_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] byte_count, byte_count_next;
  logic [3:0] high_digit, high_digit_next;
  logic       digit_bad, digit_bad_next;

  logic       do_accept;
  logic [7:0] acc_byte;
  logic [8:0] count_inc;
  logic [4:0] digit;

  assign count_inc = {1'b0, byte_count} + 9'd1;
  assign digit     = rsp_pkg::hex_value(rx_byte);

  always_comb begin
    phase_next       = phase;
    running_sum_next = running_sum;
    byte_count_next  = byte_count;
    high_digit_next  = high_digit;
    digit_bad_next   = digit_bad;
    res_valid        = 1'b0;
    res.kind         = rsp_pkg::KIND_DATA;
    res.value        = 8'h00;
    res.length       = byte_count;
    do_accept        = 1'b0;
    acc_byte         = rx_byte;
    case (phase)
      PH_BODY: begin
        if (rx_byte == rsp_pkg::CH_START) begin
          running_sum_next = 8'h00;
          byte_count_next  = 8'h00;
          res_valid        = 1'b1;
          res.kind         = rsp_pkg::KIND_RESTART;
        end else if (rx_byte == rsp_pkg::CH_END) begin
          phase_next = PH_CKHI;
        end else begin
          running_sum_next = running_sum + rx_byte;
          if (rx_byte == rsp_pkg::CH_ESC) begin
            phase_next = PH_ESC;
          end else begin
            do_accept = 1'b1;
          end
        end
      end
      PH_ESC: begin
        running_sum_next = running_sum + rx_byte;
        do_accept        = 1'b1;
        acc_byte         = rx_byte ^ rsp_pkg::ESC_XOR;
      end
      PH_CKHI: begin
        digit_bad_next  = digit[4];
        high_digit_next = digit[3:0];
        phase_next      = PH_CKLO;
      end
      PH_CKLO: begin
        phase_next     = PH_HUNT;
        digit_bad_next = 1'b0;
        res_valid      = 1'b1;
        if (!digit[4] && !digit_bad && {high_digit, digit[3:0]} == running_sum) begin
          res.kind  = rsp_pkg::KIND_ACK;
          res.value = rsp_pkg::CH_ACK;
        end else begin
          res.kind  = rsp_pkg::KIND_NAK;
          res.value = rsp_pkg::CH_NAK;
        end
      end
      default: begin
        if (rx_byte == rsp_pkg::CH_START) begin
          phase_next       = PH_BODY;
          running_sum_next = 8'h00;
          byte_count_next  = 8'h00;
          digit_bad_next   = 1'b0;
        end else begin
          phase_next = PH_HUNT;
        end
      end
    endcase
    if (do_accept) begin
      res_valid = 1'b1;
      if (count_inc >= MaxLenW) begin
        phase_next = PH_HUNT;
        res.kind   = rsp_pkg::KIND_ABORT;
        res.length = MaxLenW[7:0];
      end else begin
        phase_next      = PH_BODY;
        byte_count_next = count_inc[7:0];
        res.value       = acc_byte;
        res.length      = count_inc[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      running_sum <= 8'h00;
      byte_count  <= 8'h00;
      high_digit  <= 4'h0;
      digit_bad   <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      running_sum <= running_sum_next;
      byte_count  <= byte_count_next;
      high_digit  <= high_digit_next;
      digit_bad   <= digit_bad_next;
    end
  end

endmodule

@@ design/rsp_out_buf.sv @@
// ----------------------------------------------------------------------------
// rsp_out_buf
// Result register with a skid stage in front of the output stream.
// ----------------------------------------------------------------------------
module rsp_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rsp_pkg::result_t push_res,
  output logic             full,
  output logic             out_valid,
  output rsp_pkg::result_t out_res,
  input  logic             out_ready
);

  logic             skid_valid;
  rsp_pkg::result_t skid_res;
  logic             out_free;

  assign full     = skid_valid;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= skid_valid || push;
      end
      if (skid_valid) begin
        if (out_free) skid_valid <= 1'b0;
      end else if (push && !out_free) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : push_res;
    end
    if (!skid_valid && push && !out_free) begin
      skid_res <= push_res;
    end
  end

endmodule

@@ design/rsp_packet_receiver.sv @@
// ----------------------------------------------------------------------------
// rsp_packet_receiver
// Receiver for remote serial protocol packets, one byte per beat.
// ----------------------------------------------------------------------------
// Path: a result beat passes the input register, then the result register;
// while the skid register is full, the input register holds its byte.
// Throughput: 1 byte per cycle while the skid register is empty; checksum and
// count update combinationally between the input and result registers.
// Reset: rst, synchronous; clears the input and output valids and returns the
// packet state to hunting for the start character with zero sum and count.
// ----------------------------------------------------------------------------
module rsp_packet_receiver #(
  parameter int MAX_LEN = rsp_pkg::MaxLenDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] value, [15:8] length
  output logic [2:0]  m_tuser    // [2:0] kind
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             advance;
  logic             buf_full;
  logic             res_valid;
  rsp_pkg::result_t res;
  rsp_pkg::result_t out_res;

  assign advance  = in_valid && !buf_full;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  rsp_core #(
    .MAX_LEN(MAX_LEN)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .rx_byte  (in_byte),
    .res_valid(res_valid),
    .res      (res)
  );

  rsp_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (advance && res_valid),
    .push_res (res),
    .full     (buf_full),
    .out_valid(m_tvalid),
    .out_res  (out_res),
    .out_ready(m_tready)
  );

  assign m_tdata = {out_res.length, out_res.value};
  assign m_tuser = out_res.kind;

endmodule

@@ design/rsp_checker.sv @@
// ----------------------------------------------------------------------------
// rsp_checker
// Port-level checks for the RSP packet receiver, bound to the top level.
// ----------------------------------------------------------------------------
module rsp_checker #(
  parameter int MAX_LEN = rsp_pkg::MaxLenDefault
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [2:0]  m_tuser
);

  localparam logic [7:0] MaxLen8 = 8'(MAX_LEN);

  a_reset_clears: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled beat changed");

  a_reply_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == rsp_pkg::KIND_ACK || m_tuser == rsp_pkg::KIND_NAK) |->
      m_tdata[7:0] == ((m_tuser == rsp_pkg::KIND_ACK) ? rsp_pkg::CH_ACK : rsp_pkg::CH_NAK))
    else $error("reply character mismatch");

  a_data_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == rsp_pkg::KIND_DATA |->
      m_tdata[15:8] != 8'h00 && m_tdata[15:8] < MaxLen8)
    else $error("payload length out of range");

  a_abort_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == rsp_pkg::KIND_ABORT |->
      m_tdata[15:8] == MaxLen8 && m_tdata[7:0] == 8'h00)
    else $error("abort beat malformed");

endmodule

bind rsp_packet_receiver rsp_checker #(
  .MAX_LEN(MAX_LEN)
) u_rsp_checker (
  .clk     (clk),
  .rst     (rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rsp_packet_receiver testbench
// Feeds received bytes into the packet receiver: a few hand-built packets
// first, then random packets with random payloads, escapes, restarts,
// overflows and good or broken checksums, mixed with line noise. A behavioral
// copy of the receiver predicts each payload, ack, nak, restart and abort
// beat, and every output beat is checked against it in order. Both sides
// idle at random, and the output side stalls once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_LEN     = rsp_pkg::MaxLenDefault;
  localparam int STREAM_LEN  = 1850;
  localparam int CYCLE_LIMIT = 120000;
  localparam int STALL_AT    = 1000;
  localparam int STALL_LEN   = 400;

  typedef enum logic [2:0] {
    PH_HUNT, PH_BODY, PH_ESCAPED, PH_SUM_HI, PH_SUM_LO
  } rx_phase_t;

  typedef enum int {
    TRL_GOOD_LOWER, TRL_GOOD_UPPER, TRL_WRONG_SUM, TRL_BAD_DIGIT
  } trailer_t;

  class rsp_scoreboard;
    rx_phase_t        phase;
    logic [7:0]       sum;
    logic [7:0]       count;
    logic [3:0]       hi_nib;
    bit               hi_bad;
    rsp_pkg::result_t pending[$];
    int               errors;

    function new();
      phase  = PH_HUNT;
      sum    = '0;
      count  = '0;
      hi_nib = '0;
      hi_bad = 1'b0;
      errors = 0;
    endfunction

    function int digit_of(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - 48;
      if (c >= "a" && c <= "f") return int'(c) - 87;
      if (c >= "A" && c <= "F") return int'(c) - 55;
      return -1;
    endfunction

    function void add_result(rsp_pkg::kind_t k, logic [7:0] v, logic [7:0] len);
      rsp_pkg::result_t r;
      r.kind   = k;
      r.value  = v;
      r.length = len;
      pending.push_back(r);
    endfunction

    function void take_payload(logic [7:0] b);
      if (int'(count) + 1 >= MAX_LEN) begin
        phase = PH_HUNT;
        add_result(rsp_pkg::KIND_ABORT, 8'h00, 8'(MAX_LEN));
      end else begin
        count = count + 8'd1;
        phase = PH_BODY;
        add_result(rsp_pkg::KIND_DATA, b, count);
      end
    endfunction

    function void note_byte(logic [7:0] c);
      int d;
      bit good;
      case (phase)
        PH_BODY: begin
          if (c == rsp_pkg::CH_START) begin
            add_result(rsp_pkg::KIND_RESTART, 8'h00, count);
            sum   = '0;
            count = '0;
          end else if (c == rsp_pkg::CH_END) begin
            phase = PH_SUM_HI;
          end else begin
            sum = sum + c;
            if (c == rsp_pkg::CH_ESC) phase = PH_ESCAPED;
            else take_payload(c);
          end
        end
        PH_ESCAPED: begin
          sum = sum + c;
          take_payload(c ^ rsp_pkg::ESC_XOR);
        end
        PH_SUM_HI: begin
          d      = digit_of(c);
          hi_bad = (d < 0);
          hi_nib = 4'(d);
          phase  = PH_SUM_LO;
        end
        PH_SUM_LO: begin
          d     = digit_of(c);
          good  = (d >= 0) && !hi_bad && ({hi_nib, 4'(d)} == sum);
          phase = PH_HUNT;
          hi_bad = 1'b0;
          if (good) add_result(rsp_pkg::KIND_ACK, rsp_pkg::CH_ACK, count);
          else add_result(rsp_pkg::KIND_NAK, rsp_pkg::CH_NAK, count);
        end
        default: begin
          if (c == rsp_pkg::CH_START) begin
            phase  = PH_BODY;
            sum    = '0;
            count  = '0;
            hi_bad = 1'b0;
          end
        end
      endcase
    endfunction

    function void report_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [2:0] k, logic [7:0] v, logic [7:0] len);
      rsp_pkg::result_t r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got kind %0d value %0h length %0d",
                 $time, k, v, len);
        errors++;
        return;
      end
      r = pending.pop_front();
      report_field("kind", int'(r.kind), int'(k));
      report_field("value", int'(r.value), int'(v));
      report_field("length", int'(r.length), int'(len));
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [2:0]  m_tuser;

  rsp_scoreboard sb = new();
  logic [7:0]    stream[$];
  int            beats_in = 0;
  int            cycles = 0;
  logic          steady = 1'b0;
  logic          hold_off = 1'b0;

  rsp_packet_receiver dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("rsp_packet_receiver regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_byte(s_tdata);
        beats_in <= beats_in + 1;
      end
      if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata[7:0], m_tdata[15:8]);
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_off) m_tready <= 1'b0;
    else if (steady) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(99, 0) >= 36);
  end

  // long output stall while the sender keeps offering
  initial begin
    while (beats_in < STALL_AT) @(posedge clk);
    hold_off <= 1'b1;
    repeat (STALL_LEN) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
    if (n < 10) return 8'h30 + 8'(n);
    return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(255, 0));
    while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
    return b;
  endfunction

  task automatic add_frame(logic [7:0] body[$], trailer_t trl);
    logic [7:0] sum;
    bit         upper;
    sum   = '0;
    upper = 1'($urandom_range(1, 0));
    stream.push_back(rsp_pkg::CH_START);
    foreach (body[i]) begin
      stream.push_back(body[i]);
      sum = sum + body[i];
    end
    stream.push_back(rsp_pkg::CH_END);
    case (trl)
      TRL_GOOD_LOWER, TRL_GOOD_UPPER: begin
        upper = (trl == TRL_GOOD_UPPER);
      end
      TRL_WRONG_SUM: sum = sum ^ 8'($urandom_range(255, 1));
      default: ;
    endcase
    if (trl == TRL_BAD_DIGIT && $urandom_range(1, 0)) stream.push_back(non_hex());
    else stream.push_back(hex_char(sum[7:4], upper));
    if (trl == TRL_BAD_DIGIT && stream[$] >= 8'h30 && $urandom_range(1, 0) == 0)
      stream.push_back(non_hex());
    else if (trl == TRL_BAD_DIGIT && !(stream[$ - 1] == rsp_pkg::CH_END && stream[$] < 8'h30))
      stream.push_back(hex_char(sum[3:0], upper));
    else stream.push_back(hex_char(sum[3:0], upper));
  endtask

  task automatic build_directed();
    logic [7:0] body[$];
    stream.push_back(8'h00);
    stream.push_back(8'hff);
    body = '{8'h61};
    add_frame(body, TRL_GOOD_LOWER);
    body = {};
    add_frame(body, TRL_GOOD_UPPER);
    // escaped start, end and escape bytes stay payload
    body = '{rsp_pkg::CH_ESC, rsp_pkg::CH_START, rsp_pkg::CH_ESC, rsp_pkg::CH_END,
             rsp_pkg::CH_ESC, rsp_pkg::CH_ESC};
    add_frame(body, TRL_GOOD_UPPER);
    body = '{8'h80, 8'hff};
    add_frame(body, TRL_WRONG_SUM);
    // restart inside a packet, then a start byte taken as a checksum digit
    stream.push_back(rsp_pkg::CH_START);
    stream.push_back(8'h78);
    stream.push_back(rsp_pkg::CH_START);
    stream.push_back(rsp_pkg::CH_END);
    stream.push_back(rsp_pkg::CH_START);
    stream.push_back(8'h30);
  endtask

  task automatic build_random();
    logic [7:0] body[$];
    logic [7:0] b;
    int         len;
    int         pick;
    trailer_t   trl;
    while (stream.size() < STREAM_LEN) begin
      repeat ($urandom_range(3, 0)) stream.push_back(8'($urandom_range(255, 0)));
      body = {};
      if ($urandom_range(19, 0) == 0) len = $urandom_range(140, 120);
      else len = $urandom_range(12, 0);
      while (body.size() < len) begin
        pick = $urandom_range(99, 0);
        if (pick < 10) begin
          body.push_back(rsp_pkg::CH_ESC);
          body.push_back(8'($urandom_range(255, 0)));
        end else if (pick < 12) begin
          body.push_back(rsp_pkg::CH_START);
        end else begin
          do b = 8'($urandom_range(255, 0));
          while (b == rsp_pkg::CH_START || b == rsp_pkg::CH_END || b == rsp_pkg::CH_ESC);
          body.push_back(b);
        end
      end
      pick = $urandom_range(99, 0);
      if (pick < 35) trl = TRL_GOOD_LOWER;
      else if (pick < 70) trl = TRL_GOOD_UPPER;
      else if (pick < 85) trl = TRL_WRONG_SUM;
      else trl = TRL_BAD_DIGIT;
      // occasionally cut the packet short and leave it to the next start
      if ($urandom_range(29, 0) == 0) begin
        stream.push_back(rsp_pkg::CH_START);
        foreach (body[i]) stream.push_back(body[i]);
      end else begin
        add_frame(body, trl);
      end
    end
  endtask

  task automatic send_byte(logic [7:0] b);
    while (!steady && $urandom_range(99, 0) < 36) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk);
    while (!s_tready);
  endtask

  initial begin
    build_directed();
    build_random();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (stream[i]) begin
      steady <= (i >= 400 && i < 800);
      send_byte(stream[i]);
    end
    s_tvalid <= 1'b0;
    steady   <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("rsp_packet_receiver regression: pass");
    end else begin
      $display("rsp_packet_receiver regression: fail");
    end
    $finish;
  end

endmodule
